@@ sv/g2u_pkg.sv @@
// Shared constants and types for the GB2312 to UCS-2 stream converter.
// No dependencies; imported by g2u_pair_dec and gb2312_to_ucs2_stream.
`default_nettype none

package g2u_pkg;

    // Field widths of the stream payloads
    localparam int OP_W     = 1;
    localparam int SID_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int TIDX_W   = 13;
    localparam int UNIT_W   = 16;
    localparam int ROW_W    = 7;

    // Packed bus widths (input tdata padded to whole bytes)
    localparam int IN_FIELDS_W = SID_W + BYTE_W + TIDX_W + UNIT_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = UNIT_W + SID_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Parameter defaults
    localparam int DEF_STREAMS     = 4;
    localparam int DEF_TABLE_DEPTH = 8192;

    // Operation codes carried in tuser
    localparam logic [OP_W-1:0] OP_CONVERT  = 1'b0;
    localparam logic [OP_W-1:0] OP_TABLE_WR = 1'b1;

    // GB2312 code ranges
    localparam logic [BYTE_W-1:0] LEAD1_LO = 8'hA1;
    localparam logic [BYTE_W-1:0] LEAD1_HI = 8'hA9;
    localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hB0;
    localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hF7;
    localparam logic [BYTE_W-1:0] TRAIL_LO = 8'hA1;
    localparam logic [BYTE_W-1:0] TRAIL_HI = 8'hFE;
    localparam logic [BYTE_W-1:0] HIGH_BIT = 8'h80;

    // Rows A1..A9 are 0..8, rows B0..F7 follow from 9
    localparam logic [ROW_W-1:0]  ROW2_BASE = 7'd9;
    localparam logic [TIDX_W-1:0] ROW_LEN   = 13'd94;

    // Replacement code unit for unmapped pairs
    localparam logic [UNIT_W-1:0] REPL_UNIT = 16'hA1BC;

    // Pair decode result
    typedef struct packed {
        logic              mapped;
        logic [TIDX_W-1:0] addr;
    } t_pair_dec;

endpackage

`default_nettype wire

@@ sv/gb2312_to_ucs2_stream.sv @@
// GB2312 byte stream to UCS-2 code unit converter, top level.
// Depends on g2u_pkg and g2u_pair_dec.
//
// Usage:
//   Input channel s_axis: one transfer per item. tuser selects the operation
//   (convert a data byte, or write one mapping table entry). Table entries
//   must be loaded before any pair that maps to them is converted.
//   Output channel m_axis: one transfer per code unit; tuser is the
//   invalid-pair flag (code unit A1BC given for an unmapped pair).
//   Lead bytes and table writes give no output transfer.
// Pipeline: a code unit passes through three registers on its way to
//   m_axis: input register, decode and table read, output register.
// Throughput: one item per cycle while the output is not stalled; the
//   single-port mapping memory serves either one read or one write per item.
// Reset: synchronous, active low; clears pending lead bytes and all valid
//   flags. The mapping memory is not cleared and holds its contents.
// Stall: when m_axis_tready is low the output register holds, and each
//   earlier stage holds while the stage after it is full; s_axis_tready drops
//   only when every stage is full.
`default_nettype none

module gb2312_to_ucs2_stream #(
    parameter int STREAMS     = g2u_pkg::DEF_STREAMS,
    parameter int TABLE_DEPTH = g2u_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input channel
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] stream_id, [9:2] data_byte, [22:10] table_index,
    // [38:23] table_value, [39] zero
    input  wire logic [g2u_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [0] operation
    input  wire logic [g2u_pkg::OP_W-1:0]       s_axis_tuser,
    // output channel
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [15:0] code_unit, [17:16] stream_out, [23:18] zero
    output logic [g2u_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] invalid_pair
    output logic                                m_axis_tuser
);
    import g2u_pkg::*;

    // Only streams addressable by stream_id need a lead register
    localparam int SID_SPAN = 1 << SID_W;
    localparam int LEAD_CNT = (STREAMS < SID_SPAN) ? STREAMS : SID_SPAN;
    localparam int LIDX_W   = (LEAD_CNT > 1) ? $clog2(LEAD_CNT) : 1;
    localparam int MADDR_W  = $clog2(TABLE_DEPTH);

    // Input register
    logic                 r_s1_valid;
    logic [OP_W-1:0]      r_s1_op;
    logic [SID_W-1:0]     r_s1_sid;
    logic [BYTE_W-1:0]    r_s1_byte;
    logic [TIDX_W-1:0]    r_s1_tidx;
    logic [UNIT_W-1:0]    r_s1_tval;

    // Pending lead bytes (top bit always set, so kept as a valid flag)
    logic [LEAD_CNT-1:0]  r_lead_vld;
    logic [BYTE_W-2:0]    r_lead_low [LEAD_CNT];

    // Middle stage
    logic                 r_s2_valid;
    logic                 r_s2_use_mem;
    logic [UNIT_W-1:0]    r_s2_unit;
    logic                 r_s2_bad;
    logic [SID_W-1:0]     r_s2_sid;
    logic [UNIT_W-1:0]    r_rd_data;

    // Mapping memory
    logic [UNIT_W-1:0]    r_map_mem [TABLE_DEPTH];

    // Output register
    logic                 r_o_valid;
    logic [UNIT_W-1:0]    r_o_unit;
    logic [SID_W-1:0]     r_o_sid;
    logic                 r_o_bad;

    // Flow control
    logic                 out_free;
    logic                 s2_free;
    logic                 s1_fire;

    // Stage-one decode
    logic                 sid_ok;
    logic [LIDX_W-1:0]    lidx;
    logic                 lead_pend;
    logic [BYTE_W-1:0]    lead_byte;
    logic                 is_conv;
    logic                 is_wr;
    logic                 wr_in_range;
    logic                 set_lead;
    logic                 clr_lead;
    logic                 mem_rd;
    t_pair_dec            dec;

    logic                 n_s2_valid;
    logic                 n_s2_use_mem;
    logic [UNIT_W-1:0]    n_s2_unit;
    logic                 n_s2_bad;

    // Handshake chain, back to front
    assign out_free      = !r_o_valid || m_axis_tready;
    assign s2_free       = !r_s2_valid || out_free;
    assign s_axis_tready = !r_s1_valid || s2_free;
    assign s1_fire       = r_s1_valid && s2_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_op   <= s_axis_tuser;
            r_s1_sid  <= s_axis_tdata[SID_W-1:0];
            r_s1_byte <= s_axis_tdata[SID_W +: BYTE_W];
            r_s1_tidx <= s_axis_tdata[SID_W+BYTE_W +: TIDX_W];
            r_s1_tval <= s_axis_tdata[SID_W+BYTE_W+TIDX_W +: UNIT_W];
        end
    end

    // Lead lookup for the item's stream
    assign is_conv   = (r_s1_op == OP_CONVERT);
    assign is_wr     = (r_s1_op == OP_TABLE_WR);
    assign sid_ok    = (32'(r_s1_sid) < 32'(STREAMS));
    assign lidx      = LIDX_W'(r_s1_sid);
    assign lead_pend = r_lead_vld[lidx];
    assign lead_byte = {1'b1, r_lead_low[lidx]};

    g2u_pair_dec u_pair_dec (
        .i_lead  (lead_byte),
        .i_trail (r_s1_byte),
        .o_dec   (dec)
    );

    assign wr_in_range = (32'(r_s1_tidx) < 32'(TABLE_DEPTH));
    assign clr_lead    = is_conv && sid_ok && lead_pend;
    assign set_lead    = is_conv && sid_ok && !lead_pend
                         && ((r_s1_byte & HIGH_BIT) != '0);
    assign mem_rd      = clr_lead && dec.mapped;

    // Result selection for the middle stage
    always_comb begin
        n_s2_valid   = 1'b0;
        n_s2_use_mem = 1'b0;
        n_s2_unit    = {{(UNIT_W-BYTE_W){1'b0}}, r_s1_byte};
        n_s2_bad     = 1'b0;
        if (is_conv && sid_ok) begin
            if (lead_pend) begin
                n_s2_valid = 1'b1;
                if (dec.mapped) begin
                    n_s2_use_mem = 1'b1;
                end else begin
                    n_s2_unit = REPL_UNIT;
                    n_s2_bad  = 1'b1;
                end
            end else if (!set_lead) begin
                n_s2_valid = 1'b1;
            end
        end
    end

    // Pending lead flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_vld <= '0;
        end else if (s1_fire) begin
            if (clr_lead) begin
                r_lead_vld[lidx] <= 1'b0;
            end else if (set_lead) begin
                r_lead_vld[lidx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && set_lead) begin
            r_lead_low[lidx] <= r_s1_byte[BYTE_W-2:0];
        end
    end

    // Mapping memory: one write or one read per item
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            if (is_wr && wr_in_range) begin
                r_map_mem[MADDR_W'(r_s1_tidx)] <= r_s1_tval;
            end else if (mem_rd) begin
                r_rd_data <= r_map_mem[MADDR_W'(dec.addr)];
            end
        end
    end

    // Middle stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= s1_fire && n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_s2_use_mem <= n_s2_use_mem;
            r_s2_unit    <= n_s2_unit;
            r_s2_bad     <= n_s2_bad;
            r_s2_sid     <= r_s1_sid;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s2_valid) begin
            r_o_unit <= r_s2_use_mem ? r_rd_data : r_s2_unit;
            r_o_sid  <= r_s2_sid;
            r_o_bad  <= r_s2_bad;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, r_o_sid, r_o_unit};
    assign m_axis_tuser  = r_o_bad;

`ifndef SYNTH
    // An invalid pair always carries the replacement code unit
    a_bad_is_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_bad) |-> (r_o_unit == REPL_UNIT))
        else $error("invalid pair without replacement code unit");

    // An empty middle stage never blocks the input
    a_ready_when_s2_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s2_valid |-> s_axis_tready)
        else $error("input stalled with empty middle stage");

    // A table write leaves no result behind
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && is_wr) |=> !r_s2_valid)
        else $error("table write produced a result");

    // A lead byte that arms its stream gives no result
    a_lead_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && set_lead) |=> (!r_s2_valid && r_lead_vld[$past(lidx)]))
        else $error("lead byte handling wrong");
`endif

endmodule

`default_nettype wire

@@ sv/g2u_pair_dec.sv @@
// Lead/trail byte pair decode: range checks and mapping table address.
// Depends on g2u_pkg.
`default_nettype none

module g2u_pair_dec (
    input  wire logic [g2u_pkg::BYTE_W-1:0] i_lead,
    input  wire logic [g2u_pkg::BYTE_W-1:0] i_trail,
    output g2u_pkg::t_pair_dec              o_dec
);
    import g2u_pkg::*;

    logic              trail_ok;
    logic              lead1_ok;
    logic              lead2_ok;
    logic [ROW_W-1:0]  row;
    logic [BYTE_W-1:0] col;

    // Range checks on both bytes
    assign trail_ok = (i_trail >= TRAIL_LO) && (i_trail <= TRAIL_HI);
    assign lead1_ok = (i_lead >= LEAD1_LO) && (i_lead <= LEAD1_HI);
    assign lead2_ok = (i_lead >= LEAD2_LO) && (i_lead <= LEAD2_HI);

    // Row number from the lead byte
    always_comb begin
        if (lead1_ok) begin
            row = ROW_W'(i_lead - LEAD1_LO);
        end else begin
            row = ROW_W'(i_lead - LEAD2_LO) + ROW2_BASE;
        end
    end

    assign col = i_trail - TRAIL_LO;

    // Highest address is 7613, inside the default table depth of 8192
    assign o_dec.mapped = trail_ok && (lead1_ok || lead2_ok);
    assign o_dec.addr   = (TIDX_W'(row) * ROW_LEN) + TIDX_W'(col);

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for gb2312_to_ucs2_stream.
// Depends on g2u_pkg and the converter RTL; a class predicts each code unit
// from the accepted byte stream and checks the output transfers in order.
`timescale 1ns / 1ps

module testbench;
    import g2u_pkg::*;

    localparam int STREAM_CNT      = DEF_STREAMS;
    localparam int MAP_DEPTH       = DEF_TABLE_DEPTH;
    localparam int LAST_MAPPED     = 81 * 94 - 1;   // highest address a pair can select
    localparam int ITEMS_PER_PHASE = 480;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int STALL_LIMIT     = 2000;

    // Expected output transfer
    typedef struct {
        logic [UNIT_W-1:0] unit;
        logic [SID_W-1:0]  sid;
        logic              bad;
    } t_unit_exp;

    // Tracks lead bytes and table contents, predicts code units, checks them
    class ucs2_predictor;
        logic [BYTE_W-1:0] lead_byte [STREAM_CNT];
        logic [UNIT_W-1:0] map_mem   [MAP_DEPTH];
        bit                map_written [MAP_DEPTH];
        t_unit_exp         expected_units [$];
        int                items_taken;
        int                mismatches;

        function new();
            foreach (lead_byte[i]) lead_byte[i] = '0;
            foreach (map_written[i]) map_written[i] = 1'b0;
            items_taken = 0;
            mismatches  = 0;
        endfunction

        // Table address of a lead/trail pair; returns 0 when unmapped
        function bit pair_index(input logic [BYTE_W-1:0] lead, input logic [BYTE_W-1:0] trail,
                                output int addr);
            int row;
            addr = 0;
            if (trail < TRAIL_LO || trail > TRAIL_HI) return 1'b0;
            if (lead >= LEAD1_LO && lead <= LEAD1_HI)
                row = int'(lead) - int'(LEAD1_LO);
            else if (lead >= LEAD2_LO && lead <= LEAD2_HI)
                row = int'(lead) - int'(LEAD2_LO) + int'(ROW2_BASE);
            else
                return 1'b0;
            addr = row * int'(ROW_LEN) + (int'(trail) - int'(TRAIL_LO));
            return addr < MAP_DEPTH;
        endfunction

        // Called for every accepted input transfer
        function void take_item(input logic op, input logic [SID_W-1:0] sid,
                                input logic [BYTE_W-1:0] b, input logic [TIDX_W-1:0] idx,
                                input logic [UNIT_W-1:0] val);
            t_unit_exp         e;
            logic [BYTE_W-1:0] lead;
            int                addr;
            items_taken++;
            if (op == OP_TABLE_WR) begin
                if (int'(idx) < MAP_DEPTH) begin
                    map_mem[idx]     = val;
                    map_written[idx] = 1'b1;
                end
                return;
            end
            lead = lead_byte[sid];
            if (lead != '0) begin
                // second byte of a pair, whatever its value
                lead_byte[sid] = '0;
                if (pair_index(lead, b, addr)) begin
                    e.unit = map_mem[addr];
                    e.bad  = 1'b0;
                end else begin
                    e.unit = REPL_UNIT;
                    e.bad  = 1'b1;
                end
            end else if ((b & HIGH_BIT) == '0) begin
                e.unit = {8'h00, b};
                e.bad  = 1'b0;
            end else begin
                lead_byte[sid] = b;
                return;
            end
            e.sid = sid;
            expected_units.push_back(e);
        endfunction

        // Called for every accepted output transfer
        function void check_unit(input logic [UNIT_W-1:0] unit, input logic [SID_W-1:0] sid,
                                 input logic bad);
            t_unit_exp e;
            if (expected_units.size() == 0) begin
                $error("code unit %h on stream %0d with none expected", unit, sid);
                mismatches++;
                return;
            end
            e = expected_units.pop_front();
            if (unit !== e.unit) begin
                $error("code_unit: expected %h, got %h", e.unit, unit);
                mismatches++;
            end
            if (sid !== e.sid) begin
                $error("stream_out: expected %0d, got %0d", e.sid, sid);
                mismatches++;
            end
            if (bad !== e.bad) begin
                $error("invalid_pair: expected %0b, got %0b", e.bad, bad);
                mismatches++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [1:0] sid, [9:2] byte, [22:10] index, [38:23] value
    logic [OP_W-1:0]        s_axis_tuser;   // [0] operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [15:0] code unit, [17:16] stream
    logic                   m_axis_tuser;   // [0] invalid pair

    ucs2_predictor units = new();
    int  send_gap_pct;
    int  recv_gap_pct;
    bit  hold_go;

    gb2312_to_ucs2_stream DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(input logic op, input logic [SID_W-1:0] sid,
                             input logic [BYTE_W-1:0] b, input logic [TIDX_W-1:0] idx,
                             input logic [UNIT_W-1:0] val);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, idx, b, sid};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        units.take_item(op, sid, b, idx, val);
    endtask

    // Convert one byte; loads the table entry first if the pair would hit an empty one
    task automatic send_byte(input logic [SID_W-1:0] sid, input logic [BYTE_W-1:0] b);
        int addr;
        if (units.lead_byte[sid] != '0 && units.pair_index(units.lead_byte[sid], b, addr)
                && !units.map_written[addr])
            send_item(OP_TABLE_WR, SID_W'($urandom_range(0, 3)), BYTE_W'($urandom),
                      TIDX_W'(addr), UNIT_W'($urandom));
        send_item(OP_CONVERT, sid, b, TIDX_W'($urandom), UNIT_W'($urandom));
    endtask

    // Receiver: random back-pressure plus one long hold-off
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
            end
            @(posedge i_clk);
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            units.check_unit(m_axis_tdata[UNIT_W-1:0], m_axis_tdata[UNIT_W+SID_W-1:UNIT_W],
                             m_axis_tuser);
    end

    // Watchdog: cycles with no transfer on either side
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("FAIL gb2312_to_ucs2_stream");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        logic [SID_W-1:0]  sid;
        logic [BYTE_W-1:0] lead;
        logic [TIDX_W-1:0] idx;
        int                row;
        int                pick;
        int                stop_at;

        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_go      = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_CONVERT;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: table extremes, single bytes, good and bad pairs
        send_gap_pct = 16;
        recv_gap_pct = 61;
        send_item(OP_TABLE_WR, 2'd0, 8'h00, 13'd0, 16'hFFFF);
        send_item(OP_TABLE_WR, 2'd3, 8'hFF, TIDX_W'(LAST_MAPPED), 16'h0000);
        send_item(OP_TABLE_WR, 2'd1, 8'h5A, 13'h1FFF, 16'h5A5A);
        send_byte(2'd0, 8'h00);
        send_byte(2'd0, 8'h7F);
        send_byte(2'd1, 8'hA1);     // first row, first column
        send_byte(2'd1, 8'hA1);
        send_byte(2'd2, 8'hF7);     // last row, last column
        send_byte(2'd2, 8'hFE);
        send_byte(2'd3, 8'h80);     // lead below the mapped rows
        send_byte(2'd3, 8'hA1);
        send_byte(2'd0, 8'hA1);     // trail without the top bit
        send_byte(2'd0, 8'h7F);
        send_byte(2'd1, 8'hA9);     // trail above range
        send_byte(2'd1, 8'hFF);
        send_byte(2'd2, 8'hAA);     // lead in the gap between row blocks
        send_byte(2'd2, 8'hA1);
        send_byte(2'd3, 8'hF8);     // lead past the last row, trail below range
        send_byte(2'd3, 8'hA0);
        send_byte(2'd0, 8'hFF);
        send_byte(2'd0, 8'hFF);
        send_byte(2'd1, 8'hB0);     // pair split by a byte on another stream
        send_byte(2'd2, 8'h41);
        send_byte(2'd1, 8'hA1);

        // Random phases with different idling patterns
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_gap_pct = 16;
                    recv_gap_pct = 61;
                end
                1: begin
                    send_gap_pct = 61;
                    recv_gap_pct = 16;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                    hold_go      = 1'b1;
                end
            endcase
            stop_at = units.items_taken + ITEMS_PER_PHASE;
            while (units.items_taken < stop_at) begin
                pick = $urandom_range(0, 99);
                sid  = SID_W'($urandom_range(0, STREAM_CNT - 1));
                if (pick < 12) begin
                    // table load, mostly to addresses pairs can reach
                    if ($urandom_range(0, 9) < 6)
                        idx = TIDX_W'($urandom_range(0, LAST_MAPPED));
                    else
                        idx = TIDX_W'($urandom_range(0, MAP_DEPTH - 1));
                    send_item(OP_TABLE_WR, SID_W'($urandom), BYTE_W'($urandom), idx,
                              UNIT_W'($urandom));
                end else if (pick < 57) begin
                    // well-formed pair, sometimes split by a byte on another stream
                    row  = $urandom_range(0, 80);
                    lead = (row < 9) ? BYTE_W'(int'(LEAD1_LO) + row)
                                     : BYTE_W'(int'(LEAD2_LO) + row - 9);
                    send_byte(sid, lead);
                    if ($urandom_range(0, 9) < 3)
                        send_byte(sid + 2'd1, BYTE_W'($urandom_range(0, 127)));
                    send_byte(sid, BYTE_W'($urandom_range(TRAIL_LO, TRAIL_HI)));
                end else if (pick < 82) begin
                    send_byte(sid, BYTE_W'($urandom_range(0, 127)));
                end else begin
                    send_byte(sid, BYTE_W'($urandom_range(0, 255)));
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain
        while (units.expected_units.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (units.mismatches == 0)
            $display("PASS gb2312_to_ucs2_stream");
        else
            $display("FAIL gb2312_to_ucs2_stream");
        $finish;
    end

endmodule

@@ sim.f @@
sv/g2u_pkg.sv
sv/g2u_pair_dec.sv
sv/gb2312_to_ucs2_stream.sv
sim/testbench.sv
